>>> src/rr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and transaction types for the running RMS block.
package rr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int RMS_W       = 24;

  localparam int SUM_W  = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
  localparam int NUM_W  = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } rr_in_t;

  typedef struct packed {
    logic [RMS_W-1:0]      rms_value;
    logic [COUNT_BITS-1:0] samples_seen;
    logic                  saturated;
  } rr_out_t;

  typedef struct packed {
    logic                  valid;
    logic                  sat;
    logic [COUNT_BITS-1:0] rem;
    logic [NUM_W-1:0]      nq;
    logic [COUNT_BITS-1:0] den;
  } rr_div_t;

  typedef struct packed {
    logic                  valid;
    logic                  sat;
    logic [COUNT_BITS-1:0] cnt;
    logic [SREM_W-1:0]     rem;
    logic [ROOT_W-1:0]     root;
    logic [RAD_W-1:0]      rad;
  } rr_sqrt_t;

endpackage

>>> src/rr_div_cell.sv
`timescale 1ns / 1ps
// One restoring division cell that settles one quotient bit per transaction.
module rr_div_cell
  import rr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  rr_div_t in_d,
  output rr_div_t out_r
);

  logic [COUNT_BITS:0] trial;
  logic                take;
  rr_div_t             out_nxt;

  always_comb begin
    trial         = {in_d.rem, in_d.nq[NUM_W-1]};
    take          = (trial >= {1'b0, in_d.den});
    out_nxt       = in_d;
    out_nxt.rem   = take ? COUNT_BITS'(trial - {1'b0, in_d.den}) : trial[COUNT_BITS-1:0];
    out_nxt.nq    = {in_d.nq[NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> src/rr_sqrt_cell.sv
`timescale 1ns / 1ps
// One digit-by-digit square root cell that settles one root bit per transaction.
module rr_sqrt_cell
  import rr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  rr_sqrt_t in_d,
  output rr_sqrt_t out_r
);

  logic [SREM_W+1:0] part;
  logic [SREM_W+1:0] trial;
  logic              take;
  rr_sqrt_t          out_nxt;

  always_comb begin
    part         = {in_d.rem, in_d.rad[RAD_W-1 -: 2]};
    trial        = (SREM_W + 2)'({in_d.root, 2'b01});
    take         = (part >= trial);
    out_nxt      = in_d;
    out_nxt.rem  = take ? SREM_W'(part - trial) : SREM_W'(part);
    out_nxt.root = {in_d.root[ROOT_W-2:0], take};
    out_nxt.rad  = {in_d.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> src/running_rms.sv
`timescale 1ns / 1ps
// Running root mean square of a signed sample stream, built as a chain of cells.
//
// Each input transaction carries a signed sample and a restart flag that clears
// the running sum of squares and the sample count before the sample is taken.
// Each input transaction yields exactly one output transaction with the floored
// RMS (8 fraction bits), the current count and a saturated flag, which is set
// when the count was already at its maximum and the sample was ignored.
// The accumulator feeds a chain of division cells, one per quotient bit, and
// then a chain of square root cells, one per root bit. A result therefore
// passes through the accumulator register, each division cell and then each
// square root cell; one transaction per cycle is taken while the receiver does
// not stall, as each cell passes its work to the next on every enabled cycle.
// The whole chain advances together; when the receiver stalls with a result
// waiting, the chain holds and in_stall is raised until the result is taken.
// Reset clears the sum, the count and every valid flag in the chain.
module running_rms
  import rr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  rr_in_t  in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output rr_out_t out_data
);

  logic                   en;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [COUNT_BITS-1:0]  count_r;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic                   acc_valid_r;
  logic                   acc_sat_r;
  logic                   acc_sat_nxt;
  logic [SUM_W-1:0]       base_sum;
  logic [COUNT_BITS-1:0]  base_cnt;
  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] square;

  rr_div_t  div_s  [0:NUM_W];
  rr_sqrt_t sqrt_s [0:ROOT_W];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    base_sum    = in_data.restart ? '0 : sum_r;
    base_cnt    = in_data.restart ? '0 : count_r;
    mag         = in_data.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_data.sample)
                                                : SAMPLE_BITS'(in_data.sample);
    square      = mag * mag;
    acc_sat_nxt = (base_cnt == COUNT_MAX);
    if (acc_sat_nxt) begin
      sum_nxt   = base_sum;
      count_nxt = base_cnt;
    end else begin
      sum_nxt   = base_sum + SUM_W'(square);
      count_nxt = base_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      acc_valid_r <= 1'b0;
    end else if (en) begin
      acc_valid_r <= in_valid;
      if (in_valid) begin
        sum_r     <= sum_nxt;
        count_r   <= count_nxt;
        acc_sat_r <= acc_sat_nxt;
      end
    end
  end

  assign div_s[0] = '{valid: acc_valid_r, sat: acc_sat_r, rem: '0,
                      nq: {sum_r, {(2 * FRAC_BITS){1'b0}}}, den: count_r};

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    rr_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_d  (div_s[i]),
      .out_r (div_s[i+1])
    );
  end

  assign sqrt_s[0] = '{valid: div_s[NUM_W].valid, sat: div_s[NUM_W].sat,
                       cnt: div_s[NUM_W].den, rem: '0, root: '0,
                       rad: RAD_W'(div_s[NUM_W].nq)};

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    rr_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_d  (sqrt_s[j]),
      .out_r (sqrt_s[j+1])
    );
  end

  assign out_valid              = sqrt_s[ROOT_W].valid;
  assign out_data.rms_value     = RMS_W'(sqrt_s[ROOT_W].root);
  assign out_data.samples_seen  = sqrt_s[ROOT_W].cnt;
  assign out_data.saturated     = sqrt_s[ROOT_W].sat;

`ifndef SYNTH
  a_sat_at_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.samples_seen == COUNT_MAX)
    else $error("saturated result without a full count");

  a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    acc_valid_r |-> count_r != '0)
    else $error("transaction entered the divider with a zero count");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid && !acc_valid_r)
    else $error("valid flags survived reset");
`endif

endmodule
